// File: src/sbbp_pkg.sv
// Shared types, constants and helper functions for the bulk-dump block parser.
// No dependencies; every other file of the block but sbbp_ifs uses this package.
`default_nettype none

package sbbp_pkg;

  // Configuration register indexes.
  localparam logic [1:0] REG_MANUFACTURER = 2'd0;
  localparam logic [1:0] REG_GROUP_HIGH   = 2'd1;
  localparam logic [1:0] REG_GROUP_LOW    = 2'd2;
  localparam logic [1:0] REG_MODEL        = 2'd3;

  // Configuration reset values.
  localparam logic [6:0] RST_MANUFACTURER = 7'h43;
  localparam logic [6:0] RST_GROUP_HIGH   = 7'h7f;
  localparam logic [6:0] RST_GROUP_LOW    = 7'h1c;
  localparam logic [6:0] RST_MODEL        = 7'h05;

  // Status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FOREIGN  = 2'd1;
  localparam logic [1:0] ST_LENGTH   = 2'd2;
  localparam logic [1:0] ST_CHECKSUM = 2'd3;

  // Block kind codes.
  localparam logic [2:0] KIND_HEADER   = 3'd0;
  localparam logic [2:0] KIND_FOOTER   = 3'd1;
  localparam logic [2:0] KIND_COMMON   = 3'd2;
  localparam logic [2:0] KIND_OPERATOR = 3'd3;
  localparam logic [2:0] KIND_SYSTEM   = 3'd4;
  localparam logic [2:0] KIND_OTHER    = 3'd5;

  // Address byte patterns that identify a block.
  localparam logic [7:0] ADDR_HEADER_HI = 8'h0e;
  localparam logic [7:0] ADDR_BULK_MID  = 8'h0f;
  localparam logic [7:0] ADDR_FOOTER_HI = 8'h0f;
  localparam logic [7:0] ADDR_COMMON_HI = 8'h30;
  localparam logic [7:0] ADDR_OPER_HI   = 8'h31;
  localparam logic [7:0] ADDR_ZERO      = 8'h00;

  // Body byte positions.
  localparam logic [14:0] POS_MFR       = 15'd0;
  localparam logic [14:0] POS_GROUP_HI  = 15'd2;
  localparam logic [14:0] POS_GROUP_LO  = 15'd3;
  localparam logic [14:0] POS_COUNT_HI  = 15'd4;
  localparam logic [14:0] POS_COUNT_LO  = 15'd5;
  localparam logic [14:0] POS_MODEL     = 15'd6;
  localparam logic [14:0] POS_ADDR_HI   = 15'd7;
  localparam logic [14:0] POS_ADDR_MID  = 15'd8;
  localparam logic [14:0] POS_ADDR_LO   = 15'd9;
  localparam logic [14:0] POS_PAYLOAD   = 15'd10;
  localparam logic [14:0] POS_MAX       = 15'h7fff;

  // The checksum byte sits this many positions after the declared count.
  localparam logic [14:0] CHK_OFFSET = 15'd6;
  // Smallest count that holds the address bytes and the checksum.
  localparam logic [13:0] MIN_COUNT  = 14'd4;

  typedef struct packed {
    logic [6:0] manufacturer_id;
    logic [6:0] group_high;
    logic [6:0] group_low;
    logic [6:0] model_id;
  } cfg_t;

  typedef struct packed {
    logic [7:0] body_byte;
    logic       last_byte;
  } in_item_t;

  // Input register contents handed to the parse core.
  typedef struct packed {
    logic     valid;
    in_item_t item;
  } stage_t;

  typedef struct packed {
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic [13:0] payload_index;
    logic        done_res;
    logic [1:0]  status;
    logic [2:0]  block_kind;
    logic [7:0]  address_high;
    logic [7:0]  address_mid;
    logic [7:0]  address_low;
  } result_t;

  // Classify a block from its three address bytes.
  function automatic logic [2:0] kind_of(input logic [7:0] h, input logic [7:0] m,
                                         input logic [7:0] l);
    logic [2:0] k;
    if (h == ADDR_HEADER_HI && m == ADDR_BULK_MID && l == ADDR_ZERO) begin
      k = KIND_HEADER;
    end else if (h == ADDR_FOOTER_HI && m == ADDR_BULK_MID && l == ADDR_ZERO) begin
      k = KIND_FOOTER;
    end else if (h == ADDR_COMMON_HI && m == ADDR_ZERO && l == ADDR_ZERO) begin
      k = KIND_COMMON;
    end else if (h == ADDR_OPER_HI && l == ADDR_ZERO) begin
      k = KIND_OPERATOR;
    end else if (h == ADDR_ZERO && m == ADDR_ZERO && l == ADDR_ZERO) begin
      k = KIND_SYSTEM;
    end else begin
      k = KIND_OTHER;
    end
    return k;
  endfunction

endpackage

`default_nettype wire

// File: src/sbbp_ifs.sv
// Channel interfaces of the bulk-dump block parser: body bytes in, results out,
// and the configuration write channel. No dependencies.
`default_nettype none

interface sbbp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] body_byte;
  logic       last_byte;
  modport source (output valid, body_byte, last_byte, input ready);
  modport sink   (input valid, body_byte, last_byte, output ready);
endinterface

interface sbbp_out_if;
  logic        valid;
  logic        ready;
  logic        payload_valid;
  logic [7:0]  payload_byte;
  logic [13:0] payload_index;
  logic        done_res;
  logic [1:0]  status;
  logic [2:0]  block_kind;
  logic [7:0]  address_high;
  logic [7:0]  address_mid;
  logic [7:0]  address_low;
  modport source (output valid, payload_valid, payload_byte, payload_index, done_res,
                  status, block_kind, address_high, address_mid, address_low,
                  input ready);
  modport sink   (input valid, payload_valid, payload_byte, payload_index, done_res,
                  status, block_kind, address_high, address_mid, address_low,
                  output ready);
endinterface

interface sbbp_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] reg_index;
  logic [6:0] wdata;
  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

`default_nettype wire

// File: src/sbbp_cfg_regs.sv
// Configuration register file for the bulk-dump block parser.
// Depends on sbbp_pkg and the sbbp_cfg_if interface.
`default_nettype none

module sbbp_cfg_regs (
  input  wire logic          clk,
  input  wire logic          rst_n,
  sbbp_cfg_if.sink           cfg_ch,
  output sbbp_pkg::cfg_t     cfg
);

  sbbp_pkg::cfg_t cfg_r;

  // Writes are always taken.
  assign cfg_ch.ready = 1'b1;
  assign cfg = cfg_r;

  // Register writes by index.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.manufacturer_id <= sbbp_pkg::RST_MANUFACTURER;
      cfg_r.group_high      <= sbbp_pkg::RST_GROUP_HIGH;
      cfg_r.group_low       <= sbbp_pkg::RST_GROUP_LOW;
      cfg_r.model_id        <= sbbp_pkg::RST_MODEL;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.reg_index)
        sbbp_pkg::REG_MANUFACTURER: cfg_r.manufacturer_id <= cfg_ch.wdata;
        sbbp_pkg::REG_GROUP_HIGH:   cfg_r.group_high      <= cfg_ch.wdata;
        sbbp_pkg::REG_GROUP_LOW:    cfg_r.group_low       <= cfg_ch.wdata;
        sbbp_pkg::REG_MODEL:        cfg_r.model_id        <= cfg_ch.wdata;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: src/sbbp_in_stage.sv
// Input register of the bulk-dump block parser: holds one body byte until the
// parse core takes it. Depends on sbbp_pkg and the sbbp_in_if interface.
`default_nettype none

module sbbp_in_stage (
  input  wire logic          clk,
  input  wire logic          rst_n,
  sbbp_in_if.sink            in_ch,
  input  wire logic          take,
  output sbbp_pkg::stage_t   stage
);

  logic               valid_r;
  sbbp_pkg::in_item_t item_r;
  logic               load;

  // A new item may enter when the register is empty or being emptied.
  assign in_ch.ready = !valid_r || take;
  assign load        = in_ch.valid && in_ch.ready;

  assign stage.valid = valid_r;
  assign stage.item  = item_r;

  // Occupancy flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (take) begin
      valid_r <= 1'b0;
    end
  end

  // Item payload; no reset needed.
  always_ff @(posedge clk) begin
    if (load) begin
      item_r.body_byte <= in_ch.body_byte;
      item_r.last_byte <= in_ch.last_byte;
    end
  end

endmodule

`default_nettype wire

// File: src/sbbp_parse_core.sv
// Message state, per-byte parsing logic and the result register of the
// bulk-dump block parser. Depends on sbbp_pkg and the sbbp_out_if interface.
`default_nettype none

module sbbp_parse_core (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire sbbp_pkg::cfg_t   cfg,
  input  wire sbbp_pkg::stage_t stage,
  output logic               take,
  sbbp_out_if.source         out_ch
);

  // Message state.
  logic [14:0] pos_r, pos_nxt;
  logic [13:0] cnt_r, cnt_nxt;
  logic        hdr_ok_r, hdr_ok_nxt;
  logic [6:0]  sum_r, sum_nxt;
  logic        chk_ok_r, chk_ok_nxt;
  logic [7:0]  addr_hi_r, addr_hi_nxt;
  logic [7:0]  addr_mid_r, addr_mid_nxt;
  logic [7:0]  addr_lo_r, addr_lo_nxt;

  // Result register.
  logic              res_valid_r;
  sbbp_pkg::result_t res_r, res_nxt;

  // Working signals.
  logic [7:0]  b;
  logic        last;
  logic [14:0] chk_pos;
  logic        in_data;
  logic        at_chk;
  logic        mismatch;
  logic [6:0]  neg_sum;
  logic [14:0] pay_off;
  logic [1:0]  st;

  // The held item moves on when the result register is free or being read.
  assign take = stage.valid && (!res_valid_r || out_ch.ready);

  assign b    = stage.item.body_byte;
  assign last = stage.item.last_byte;

  // Header checks, byte count capture and address capture.
  always_comb begin
    mismatch = 1'b0;
    cnt_nxt  = cnt_r;
    case (pos_r)
      sbbp_pkg::POS_MFR:      mismatch = (b != {1'b0, cfg.manufacturer_id});
      sbbp_pkg::POS_GROUP_HI: mismatch = (b != {1'b0, cfg.group_high});
      sbbp_pkg::POS_GROUP_LO: mismatch = (b != {1'b0, cfg.group_low});
      sbbp_pkg::POS_COUNT_HI: cnt_nxt  = {b[6:0], 7'd0};
      sbbp_pkg::POS_COUNT_LO: cnt_nxt  = {cnt_r[13:7], b[6:0]};
      sbbp_pkg::POS_MODEL:    mismatch = (b != {1'b0, cfg.model_id});
      default: ;
    endcase
    hdr_ok_nxt = hdr_ok_r && !mismatch;

    addr_hi_nxt  = (pos_r == sbbp_pkg::POS_ADDR_HI)  ? b : addr_hi_r;
    addr_mid_nxt = (pos_r == sbbp_pkg::POS_ADDR_MID) ? b : addr_mid_r;
    addr_lo_nxt  = (pos_r == sbbp_pkg::POS_ADDR_LO)  ? b : addr_lo_r;
  end

  // Data zone, running sum and checksum byte check.
  always_comb begin
    chk_pos = {1'b0, cnt_nxt} + sbbp_pkg::CHK_OFFSET;
    in_data = (pos_r >= sbbp_pkg::POS_ADDR_HI) && (pos_r < chk_pos);
    at_chk  = (pos_r >= sbbp_pkg::POS_ADDR_HI) && (pos_r == chk_pos);
    neg_sum = 7'd0 - sum_r;

    sum_nxt = sum_r;
    if (in_data || pos_r == sbbp_pkg::POS_MODEL) begin
      sum_nxt = sum_r + b[6:0];
    end
    chk_ok_nxt = chk_ok_r;
    if (at_chk) begin
      chk_ok_nxt = (b == {1'b0, neg_sum});
    end
  end

  // Result assembly.
  always_comb begin
    pay_off = pos_r - sbbp_pkg::POS_PAYLOAD;
    if (pos_r < sbbp_pkg::POS_MODEL || !hdr_ok_nxt) begin
      st = sbbp_pkg::ST_FOREIGN;
    end else if (pos_r != chk_pos || cnt_nxt < sbbp_pkg::MIN_COUNT) begin
      st = sbbp_pkg::ST_LENGTH;
    end else if (!chk_ok_nxt) begin
      st = sbbp_pkg::ST_CHECKSUM;
    end else begin
      st = sbbp_pkg::ST_OK;
    end

    res_nxt = '0;
    if (in_data && pos_r >= sbbp_pkg::POS_PAYLOAD && hdr_ok_nxt) begin
      res_nxt.payload_valid = 1'b1;
      res_nxt.payload_byte  = b;
      res_nxt.payload_index = pay_off[13:0];
    end
    if (last) begin
      res_nxt.done_res     = 1'b1;
      res_nxt.status       = st;
      res_nxt.block_kind   = sbbp_pkg::kind_of(addr_hi_nxt, addr_mid_nxt, addr_lo_nxt);
      res_nxt.address_high = addr_hi_nxt;
      res_nxt.address_mid  = addr_mid_nxt;
      res_nxt.address_low  = addr_lo_nxt;
    end
  end

  // Position advances, saturating; the next position after a final byte is zero.
  always_comb begin
    if (last) begin
      pos_nxt = '0;
    end else if (pos_r != sbbp_pkg::POS_MAX) begin
      pos_nxt = pos_r + 15'd1;
    end else begin
      pos_nxt = pos_r;
    end
  end

  // Message state update; everything returns to its reset value after a final byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      cnt_r      <= '0;
      hdr_ok_r   <= 1'b1;
      sum_r      <= '0;
      chk_ok_r   <= 1'b0;
      addr_hi_r  <= '0;
      addr_mid_r <= '0;
      addr_lo_r  <= '0;
    end else if (take) begin
      pos_r <= pos_nxt;
      if (last) begin
        cnt_r      <= '0;
        hdr_ok_r   <= 1'b1;
        sum_r      <= '0;
        chk_ok_r   <= 1'b0;
        addr_hi_r  <= '0;
        addr_mid_r <= '0;
        addr_lo_r  <= '0;
      end else begin
        cnt_r      <= cnt_nxt;
        hdr_ok_r   <= hdr_ok_nxt;
        sum_r      <= sum_nxt;
        chk_ok_r   <= chk_ok_nxt;
        addr_hi_r  <= addr_hi_nxt;
        addr_mid_r <= addr_mid_nxt;
        addr_lo_r  <= addr_lo_nxt;
      end
    end
  end

  // Result register occupancy.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (take) begin
      res_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      res_valid_r <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (take) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid         = res_valid_r;
  assign out_ch.payload_valid = res_r.payload_valid;
  assign out_ch.payload_byte  = res_r.payload_byte;
  assign out_ch.payload_index = res_r.payload_index;
  assign out_ch.done_res      = res_r.done_res;
  assign out_ch.status        = res_r.status;
  assign out_ch.block_kind    = res_r.block_kind;
  assign out_ch.address_high  = res_r.address_high;
  assign out_ch.address_mid   = res_r.address_mid;
  assign out_ch.address_low   = res_r.address_low;

endmodule

`default_nettype wire

// File: src/sysex_bulk_block_parser.sv
// Top level of the bulk-dump block parser: input register, parse core with its
// result register, and configuration registers. Depends on sbbp_pkg, sbbp_ifs and those modules.
//
//   channel  direction  carries                                     handshake
//   in_ch    sink       body_byte, last_byte                        valid/ready
//   out_ch   source     payload fields, done_res, status, kind, addr valid/ready
//   cfg_ch   sink       reg_index, wdata                            valid/ready
//
// One item per cycle is sustained while the output is not stalled; each item passes through
// the input register and then the result register before its result is offered.
// The running sum and byte position update once per byte.
// Reset (rst_n low, synchronous) clears the message state and loads register defaults.
// A stalled output holds its result; the input register still takes one more item.
// Configuration writes are always accepted.
`default_nettype none

module sysex_bulk_block_parser (
  input  wire logic clk,
  input  wire logic rst_n,
  sbbp_in_if.sink   in_ch,
  sbbp_out_if.source out_ch,
  sbbp_cfg_if.sink  cfg_ch
);

  sbbp_pkg::cfg_t   cfg;
  sbbp_pkg::stage_t stage;
  logic             take;

  sbbp_cfg_regs u_cfg_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  sbbp_in_stage u_in_stage (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .take  (take),
    .stage (stage)
  );

  sbbp_parse_core u_parse_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .stage  (stage),
    .take   (take),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire

// File: src/sbbp_checker.sv
// Port-level checks on the bulk-dump block parser and the bind that attaches them.
// Depends on sbbp_pkg and the top level sysex_bulk_block_parser.
`default_nettype none

module sbbp_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        payload_valid,
  input wire logic [7:0]  payload_byte,
  input wire logic [13:0] payload_index,
  input wire logic        done_res,
  input wire logic [1:0]  status,
  input wire logic [2:0]  block_kind,
  input wire logic [7:0]  address_high,
  input wire logic [7:0]  address_mid,
  input wire logic [7:0]  address_low
);

  // A result waiting on the sink stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

  // Without a payload byte the payload fields are zero.
  a_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !payload_valid |-> payload_byte == 8'd0 && payload_index == 14'd0)
    else $error("payload fields set without payload");

  // Verdict fields are zero except on the final byte.
  a_verdict_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !done_res |-> status == sbbp_pkg::ST_OK &&
      block_kind == sbbp_pkg::KIND_HEADER && address_high == 8'd0 &&
      address_mid == 8'd0 && address_low == 8'd0)
    else $error("verdict fields set before the final byte");

  // A header block kind agrees with the reported address.
  a_header_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && done_res && block_kind == sbbp_pkg::KIND_HEADER |->
      address_high == sbbp_pkg::ADDR_HEADER_HI &&
      address_mid == sbbp_pkg::ADDR_BULK_MID && address_low == sbbp_pkg::ADDR_ZERO)
    else $error("header kind with a non-header address");

endmodule

bind sysex_bulk_block_parser sbbp_checker u_sbbp_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .payload_valid (out_ch.payload_valid),
  .payload_byte  (out_ch.payload_byte),
  .payload_index (out_ch.payload_index),
  .done_res      (out_ch.done_res),
  .status        (out_ch.status),
  .block_kind    (out_ch.block_kind),
  .address_high  (out_ch.address_high),
  .address_mid   (out_ch.address_mid),
  .address_low   (out_ch.address_low)
);

`default_nettype wire

// File: bench/sbbp_result_checker.sv
// Result checker for the bulk-dump block parser: watches the three channels, predicts
// every result from the accepted items and compares. Depends on sbbp_pkg and sbbp_ifs.
`default_nettype none

module sbbp_result_checker (
  input  wire logic clk,
  input  wire logic rst_n,
  sbbp_in_if   in_mon,
  sbbp_out_if  out_mon,
  sbbp_cfg_if  cfg_mon,
  output int   fail_count,
  output int   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REPORT_LIMIT = 10;

  // Expected header bytes, as the block's registers should hold them.
  logic [6:0]  want_mfr;
  logic [6:0]  want_group_hi;
  logic [6:0]  want_group_lo;
  logic [6:0]  want_model;

  // Parse state of the message in flight.
  int          body_pos;
  logic [13:0] byte_count;
  logic        header_ok;
  logic [6:0]  sum7;
  logic        check_ok;
  logic [7:0]  addr_bytes [3];

  sbbp_pkg::result_t pending_results [$];
  int          errors = 0;

  function automatic void clear_frame();
    body_pos   = 0;
    byte_count = '0;
    header_ok  = 1'b1;
    sum7       = '0;
    check_ok   = 1'b0;
    addr_bytes[0] = '0;
    addr_bytes[1] = '0;
    addr_bytes[2] = '0;
  endfunction

  // Block kind from the three address bytes, keyed on the high byte first.
  function automatic logic [2:0] block_kind_for(input logic [7:0] h, input logic [7:0] m,
                                                input logic [7:0] l);
    logic [2:0] k;
    k = sbbp_pkg::KIND_OTHER;
    case (h)
      sbbp_pkg::ADDR_HEADER_HI:
        if (m == sbbp_pkg::ADDR_BULK_MID && l == sbbp_pkg::ADDR_ZERO)
          k = sbbp_pkg::KIND_HEADER;
      sbbp_pkg::ADDR_FOOTER_HI:
        if (m == sbbp_pkg::ADDR_BULK_MID && l == sbbp_pkg::ADDR_ZERO)
          k = sbbp_pkg::KIND_FOOTER;
      sbbp_pkg::ADDR_COMMON_HI:
        if (m == sbbp_pkg::ADDR_ZERO && l == sbbp_pkg::ADDR_ZERO)
          k = sbbp_pkg::KIND_COMMON;
      sbbp_pkg::ADDR_OPER_HI:
        if (l == sbbp_pkg::ADDR_ZERO) k = sbbp_pkg::KIND_OPERATOR;
      sbbp_pkg::ADDR_ZERO:
        if (m == sbbp_pkg::ADDR_ZERO && l == sbbp_pkg::ADDR_ZERO)
          k = sbbp_pkg::KIND_SYSTEM;
      default:        k = sbbp_pkg::KIND_OTHER;
    endcase
    return k;
  endfunction

  // Advance the parse state by one body byte and return the result it causes.
  function automatic sbbp_pkg::result_t parse_body_byte(input logic [7:0] b,
                                                        input logic last_b);
    sbbp_pkg::result_t r;
    int         p;
    int         chk_pos;
    logic [6:0] neg_sum;
    r = '0;
    p = body_pos;

    // Header bytes: match checks, byte count and the model byte.
    case (p)
      int'(sbbp_pkg::POS_MFR):      if (b != {1'b0, want_mfr}) header_ok = 1'b0;
      int'(sbbp_pkg::POS_GROUP_HI): if (b != {1'b0, want_group_hi}) header_ok = 1'b0;
      int'(sbbp_pkg::POS_GROUP_LO): if (b != {1'b0, want_group_lo}) header_ok = 1'b0;
      int'(sbbp_pkg::POS_COUNT_HI): byte_count = {b[6:0], 7'd0};
      int'(sbbp_pkg::POS_COUNT_LO): byte_count[6:0] = b[6:0];
      int'(sbbp_pkg::POS_MODEL): begin
        if (b != {1'b0, want_model}) header_ok = 1'b0;
        sum7 = sum7 + b[6:0];
      end
      default: ;
    endcase
    chk_pos = int'(byte_count) + int'(sbbp_pkg::CHK_OFFSET);

    if (p >= int'(sbbp_pkg::POS_ADDR_HI) && p <= int'(sbbp_pkg::POS_ADDR_LO)) begin
      addr_bytes[p - int'(sbbp_pkg::POS_ADDR_HI)] = b;
    end

    // Data bytes feed the checksum; those past the address are payload.
    if (p >= int'(sbbp_pkg::POS_ADDR_HI) && p < chk_pos) begin
      sum7 = sum7 + b[6:0];
      if (p >= int'(sbbp_pkg::POS_PAYLOAD) && header_ok) begin
        r.payload_valid = 1'b1;
        r.payload_byte  = b;
        r.payload_index = 14'(p - int'(sbbp_pkg::POS_PAYLOAD));
      end
    end else if (p >= int'(sbbp_pkg::POS_ADDR_HI) && p == chk_pos) begin
      neg_sum  = 7'd0 - sum7;
      check_ok = (b == {1'b0, neg_sum});
    end

    // Verdict on the final byte; foreign beats length, length beats checksum.
    if (last_b) begin
      r.done_res = 1'b1;
      if (p < int'(sbbp_pkg::POS_MODEL) || !header_ok) begin
        r.status = sbbp_pkg::ST_FOREIGN;
      end else if (p != chk_pos || byte_count < sbbp_pkg::MIN_COUNT) begin
        r.status = sbbp_pkg::ST_LENGTH;
      end else if (!check_ok) begin
        r.status = sbbp_pkg::ST_CHECKSUM;
      end else begin
        r.status = sbbp_pkg::ST_OK;
      end
      r.block_kind   = block_kind_for(addr_bytes[0], addr_bytes[1], addr_bytes[2]);
      r.address_high = addr_bytes[0];
      r.address_mid  = addr_bytes[1];
      r.address_low  = addr_bytes[2];
      clear_frame();
    end else if (body_pos < int'(sbbp_pkg::POS_MAX)) begin
      body_pos = p + 1;
    end
    return r;
  endfunction

  function automatic bit same_result(input sbbp_pkg::result_t w,
                                     input sbbp_pkg::result_t g);
    return (w.payload_valid === g.payload_valid) && (w.payload_byte === g.payload_byte) &&
           (w.payload_index === g.payload_index) && (w.done_res === g.done_res) &&
           (w.status === g.status) && (w.block_kind === g.block_kind) &&
           (w.address_high === g.address_high) && (w.address_mid === g.address_mid) &&
           (w.address_low === g.address_low);
  endfunction

  task automatic note_failure(input string what, input sbbp_pkg::result_t w,
                              input sbbp_pkg::result_t g);
    errors++;
    if (errors <= REPORT_LIMIT) begin
      $display("%0t %s: expected pv=%0d pb=%h pi=%0d done=%0d st=%0d kind=%0d addr=%h %h %h",
               $realtime, what, w.payload_valid, w.payload_byte, w.payload_index,
               w.done_res, w.status, w.block_kind, w.address_high, w.address_mid,
               w.address_low);
      $display("%0t %s: actual   pv=%0d pb=%h pi=%0d done=%0d st=%0d kind=%0d addr=%h %h %h",
               $realtime, what, g.payload_valid, g.payload_byte, g.payload_index,
               g.done_res, g.status, g.block_kind, g.address_high, g.address_mid,
               g.address_low);
    end
  endtask

  // Everything is sampled at the rising edge, before the edge's own updates land.
  always @(posedge clk) begin
    sbbp_pkg::result_t want;
    sbbp_pkg::result_t got;
    sbbp_pkg::result_t predicted;
    if (!rst_n) begin
      want_mfr      = sbbp_pkg::RST_MANUFACTURER;
      want_group_hi = sbbp_pkg::RST_GROUP_HIGH;
      want_group_lo = sbbp_pkg::RST_GROUP_LOW;
      want_model    = sbbp_pkg::RST_MODEL;
      clear_frame();
      pending_results.delete();
    end else begin
      // Register writes.
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.reg_index)
          sbbp_pkg::REG_MANUFACTURER: want_mfr      = cfg_mon.wdata;
          sbbp_pkg::REG_GROUP_HIGH:   want_group_hi = cfg_mon.wdata;
          sbbp_pkg::REG_GROUP_LOW:    want_group_lo = cfg_mon.wdata;
          sbbp_pkg::REG_MODEL:        want_model    = cfg_mon.wdata;
          default: ;
        endcase
      end

      // Accepted results against the oldest expectation.
      if (out_mon.valid && out_mon.ready) begin
        got.payload_valid = out_mon.payload_valid;
        got.payload_byte  = out_mon.payload_byte;
        got.payload_index = out_mon.payload_index;
        got.done_res      = out_mon.done_res;
        got.status        = out_mon.status;
        got.block_kind    = out_mon.block_kind;
        got.address_high  = out_mon.address_high;
        got.address_mid   = out_mon.address_mid;
        got.address_low   = out_mon.address_low;
        if (pending_results.size() == 0) begin
          note_failure("unexpected result", '0, got);
        end else begin
          want = pending_results.pop_front();
          if (!same_result(want, got)) note_failure("mismatch", want, got);
        end
      end

      // Accepted items.
      if (in_mon.valid && in_mon.ready) begin
        predicted = parse_body_byte(in_mon.body_byte, in_mon.last_byte);
        pending_results.insert(pending_results.size(), predicted);
      end
    end
    fail_count  <= errors;
    outstanding <= pending_results.size();
  end

endmodule

`default_nettype wire

// File: bench/tb_sysex_bulk_block_parser.sv
// Testbench top for the bulk-dump block parser: clock, reset, message stimulus,
// random idling on both channels and the verdict. Depends on sbbp_pkg, sbbp_ifs, the checker.
`default_nettype none

module tb_sysex_bulk_block_parser;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TOTAL_ITEMS = 1100;
  localparam int PHASE_ITEMS = 170;
  localparam int HOLD_CYCLES = 80;
  localparam int STALL_LIMIT = 3000;

  typedef enum int {
    FRAME_GOOD, FRAME_FOREIGN, FRAME_BAD_LENGTH, FRAME_SHORT_COUNT,
    FRAME_BAD_CHECKSUM, FRAME_TRUNCATED, FRAME_NOISE
  } frame_kind_t;

  logic clk;
  logic rst_n;

  sbbp_in_if  in_ch ();
  sbbp_out_if out_ch ();
  sbbp_cfg_if cfg_ch ();

  int         fail_total;
  int         pending;
  int         items_sent;
  int         in_idle_max;
  int         out_idle_max;
  bit         hold_results;
  int         quiet_cycles;
  logic [6:0] cur_mfr;
  logic [6:0] cur_group_hi;
  logic [6:0] cur_group_lo;
  logic [6:0] cur_model;
  logic [7:0] body_q [$];

  sysex_bulk_block_parser dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  sbbp_result_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .cfg_mon     (cfg_ch),
    .fail_count  (fail_total),
    .outstanding (pending)
  );

  // Clock.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Append one byte to the message body.
  function automatic void add_byte(input logic [7:0] b);
    body_q.insert(body_q.size(), b);
  endfunction

  // Offer one body byte after a random gap and wait until it is taken.
  task automatic offer_byte(input logic [7:0] b, input logic last_b);
    int gap;
    gap = $urandom_range(0, in_idle_max);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.body_byte <= b;
    in_ch.last_byte <= last_b;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  task automatic send_body();
    for (int i = 0; i < body_q.size(); i++) begin
      offer_byte(body_q[i], i == body_q.size() - 1);
    end
  endtask

  // Build a well-formed body for the current registers with a declared count of n.
  // Counts below four get plain random data instead of address and checksum.
  task automatic build_frame(input int n, input logic [7:0] ah, input logic [7:0] am,
                             input logic [7:0] al, input logic [1:0] count_marks);
    logic [13:0] cnt;
    logic [6:0]  sum;
    logic [7:0]  b;
    cnt = 14'(n);
    body_q.delete();
    add_byte({1'b0, cur_mfr});
    add_byte(8'($urandom_range(0, 255)));
    add_byte({1'b0, cur_group_hi});
    add_byte({1'b0, cur_group_lo});
    add_byte({count_marks[1], cnt[13:7]});
    add_byte({count_marks[0], cnt[6:0]});
    add_byte({1'b0, cur_model});
    sum = cur_model;
    if (n >= int'(sbbp_pkg::MIN_COUNT)) begin
      add_byte(ah);
      add_byte(am);
      add_byte(al);
      sum = sum + ah[6:0] + am[6:0] + al[6:0];
      repeat (n - int'(sbbp_pkg::MIN_COUNT)) begin
        b = 8'($urandom_range(0, 255));
        add_byte(b);
        sum = sum + b[6:0];
      end
      add_byte({1'b0, 7'd0 - sum});
    end else begin
      repeat (n) add_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // One random message: mostly well formed, the rest broken or plain noise.
  task automatic send_random_message();
    int          sel;
    int          n;
    int          keep;
    frame_kind_t kind;
    logic [7:0]  ah;
    logic [7:0]  am;
    logic [7:0]  al;
    in_idle_max  = ($urandom_range(0, 3) == 0) ? 0 : 13;
    out_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 13;

    sel = $urandom_range(0, 99);
    if (sel < 50)      kind = FRAME_GOOD;
    else if (sel < 58) kind = FRAME_FOREIGN;
    else if (sel < 66) kind = FRAME_BAD_LENGTH;
    else if (sel < 72) kind = FRAME_SHORT_COUNT;
    else if (sel < 82) kind = FRAME_BAD_CHECKSUM;
    else if (sel < 90) kind = FRAME_TRUNCATED;
    else               kind = FRAME_NOISE;

    // Mostly short blocks, now and then a long one.
    sel = $urandom_range(0, 99);
    if (sel < 80)      n = $urandom_range(4, 20);
    else if (sel < 97) n = $urandom_range(21, 90);
    else               n = $urandom_range(91, 260);

    // Block address: each known kind, near misses and random bytes.
    case ($urandom_range(0, 6))
      0: begin
        ah = sbbp_pkg::ADDR_HEADER_HI; am = sbbp_pkg::ADDR_BULK_MID; al = sbbp_pkg::ADDR_ZERO;
      end
      1: begin
        ah = sbbp_pkg::ADDR_FOOTER_HI; am = sbbp_pkg::ADDR_BULK_MID; al = sbbp_pkg::ADDR_ZERO;
      end
      2: begin
        ah = sbbp_pkg::ADDR_COMMON_HI; am = sbbp_pkg::ADDR_ZERO; al = sbbp_pkg::ADDR_ZERO;
      end
      3: begin
        ah = sbbp_pkg::ADDR_OPER_HI;
        am = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 5)) :
                                           8'($urandom_range(0, 255));
        al = sbbp_pkg::ADDR_ZERO;
      end
      4: begin
        ah = sbbp_pkg::ADDR_ZERO; am = sbbp_pkg::ADDR_ZERO; al = sbbp_pkg::ADDR_ZERO;
      end
      5: begin
        case ($urandom_range(0, 4))
          0: ah = sbbp_pkg::ADDR_HEADER_HI;
          1: ah = sbbp_pkg::ADDR_FOOTER_HI;
          2: ah = sbbp_pkg::ADDR_COMMON_HI;
          3: ah = sbbp_pkg::ADDR_OPER_HI;
          default: ah = sbbp_pkg::ADDR_ZERO;
        endcase
        am = 8'($urandom_range(0, 16));
        al = 8'($urandom_range(0, 1));
      end
      default: begin
        ah = 8'($urandom_range(0, 255));
        am = 8'($urandom_range(0, 255));
        al = 8'($urandom_range(0, 255));
      end
    endcase

    if (kind == FRAME_SHORT_COUNT) n = $urandom_range(0, 3);
    build_frame(n, ah, am, al, 2'($urandom_range(0, 3)));

    case (kind)
      FRAME_FOREIGN: begin
        case ($urandom_range(0, 3))
          0: body_q[sbbp_pkg::POS_MFR]      ^= 8'($urandom_range(1, 255));
          1: body_q[sbbp_pkg::POS_GROUP_HI] ^= 8'($urandom_range(1, 255));
          2: body_q[sbbp_pkg::POS_GROUP_LO] ^= 8'($urandom_range(1, 255));
          default: body_q[sbbp_pkg::POS_MODEL] ^= 8'($urandom_range(1, 255));
        endcase
      end
      FRAME_BAD_LENGTH: begin
        if ($urandom_range(0, 1) == 0) begin
          repeat ($urandom_range(1, 3)) void'(body_q.pop_back());
        end else begin
          repeat ($urandom_range(1, 4)) add_byte(8'($urandom_range(0, 255)));
        end
      end
      FRAME_BAD_CHECKSUM: begin
        if ($urandom_range(0, 1) == 0) begin
          body_q[body_q.size() - 1] ^= 8'($urandom_range(1, 127));
        end else begin
          body_q[body_q.size() - 1] |= 8'h80;
        end
      end
      FRAME_TRUNCATED: begin
        keep = $urandom_range(1, 9);
        while (body_q.size() > keep) void'(body_q.pop_back());
      end
      FRAME_NOISE: begin
        body_q.delete();
        repeat ($urandom_range(1, 16)) add_byte(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 1) == 0) body_q[sbbp_pkg::POS_MFR] = {1'b0, cur_mfr};
      end
      default: ;
    endcase
    send_body();
  endtask

  // Stop offering and wait until every expected result has come out.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // One register write; valid stays high for a following write.
  task automatic write_reg(input logic [1:0] idx, input logic [6:0] value);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.wdata     <= value;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  task automatic program_regs(input logic [6:0] m, input logic [6:0] gh,
                              input logic [6:0] gl, input logic [6:0] md);
    cur_mfr      = m;
    cur_group_hi = gh;
    cur_group_lo = gl;
    cur_model    = md;
    write_reg(sbbp_pkg::REG_MANUFACTURER, m);
    write_reg(sbbp_pkg::REG_GROUP_HIGH, gh);
    write_reg(sbbp_pkg::REG_GROUP_LOW, gl);
    write_reg(sbbp_pkg::REG_MODEL, md);
    cfg_ch.valid <= 1'b0;
  endtask

  // Result side: random stalls per item, and one long hold when asked.
  initial begin
    int gap;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_results) begin
        gap = HOLD_CYCLES;
        hold_results = 1'b0;
      end else begin
        gap = $urandom_range(0, out_idle_max);
      end
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
    end
  end

  // Watchdog: too long without any item moving on any channel.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stimulus and verdict.
  initial begin
    int  phase_end;
    bit  held;
    in_ch.valid      <= 1'b0;
    in_ch.body_byte  <= '0;
    in_ch.last_byte  <= 1'b0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.reg_index <= sbbp_pkg::REG_MANUFACTURER;
    cfg_ch.wdata     <= '0;
    rst_n            <= 1'b0;
    items_sent       = 0;
    in_idle_max      = 0;
    out_idle_max     = 0;
    hold_results     = 1'b0;
    held             = 1'b0;
    cur_mfr          = sbbp_pkg::RST_MANUFACTURER;
    cur_group_hi     = sbbp_pkg::RST_GROUP_HIGH;
    cur_group_lo     = sbbp_pkg::RST_GROUP_LOW;
    cur_model        = sbbp_pkg::RST_MODEL;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: minimal good header block, a lone 0xff byte, and an operator
    // block with bit 7 set on both count bytes.
    build_frame(4, sbbp_pkg::ADDR_HEADER_HI, sbbp_pkg::ADDR_BULK_MID, sbbp_pkg::ADDR_ZERO,
                2'b00);
    send_body();
    body_q.delete();
    add_byte(8'hff);
    send_body();
    build_frame(5, sbbp_pkg::ADDR_OPER_HI, 8'hff, sbbp_pkg::ADDR_ZERO, 2'b11);
    send_body();

    // Random phases, each under its own register setting.
    for (int phase = 0; items_sent < TOTAL_ITEMS; phase++) begin
      if (phase > 0) begin
        drain();
        repeat (4) @(posedge clk);
        case (phase)
          1: program_regs(7'h00, 7'h00, 7'h00, 7'h00);
          2: program_regs(7'h7f, 7'h7f, 7'h7f, 7'h7f);
          4: program_regs(sbbp_pkg::RST_MANUFACTURER, sbbp_pkg::RST_GROUP_HIGH,
                          sbbp_pkg::RST_GROUP_LOW, sbbp_pkg::RST_MODEL);
          default: program_regs(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                                7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
        endcase
      end
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end && items_sent < TOTAL_ITEMS) begin
        if (phase == 2 && !held) begin
          // Hold the result side while bytes keep coming back to back.
          held         = 1'b1;
          hold_results = 1'b1;
          in_idle_max  = 0;
          out_idle_max = 0;
          build_frame(40, sbbp_pkg::ADDR_COMMON_HI, sbbp_pkg::ADDR_ZERO,
                      sbbp_pkg::ADDR_ZERO, 2'b00);
          send_body();
        end else begin
          send_random_message();
        end
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (fail_total == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
